FILE: rtl/lafs_pkg.sv
`timescale 1ns / 1ps

package lafs_pkg;

  localparam int unsigned ChannelW   = 4;
  localparam int unsigned LoadW      = 10;
  localparam int unsigned RateW      = 12;
  localparam int unsigned CountW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;

  localparam logic [LoadW-1:0]  LoadHigh = LoadW'(230);
  localparam logic [RateW-1:0]  RateFast = RateW'(560);
  localparam logic [CountW-1:0] CountTop = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOAD_THRESHOLD = 2'd0,
    CFG_MAX_SKIPS      = 2'd1,
    CFG_PRIO_ACTIVE    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LoadW-1:0]  load_threshold;
    logic [CountW-1:0] max_skips;
    logic              prio_active;
  } cfg_t;

endpackage

FILE: rtl/load_aware_frame_skipper_core.sv
`timescale 1ns / 1ps

// Frame skip/process decision per channel with a consecutive-skip counter per
// channel. Throughput is one frame word per clock with no bubbles while the
// output is not stalled, even when the same channel arrives back to back: the
// counter is read, decided on and written back between the input register and
// the result register, which an accepted word passes through in that order.
// Counters clear at reset. Frames for a channel at or beyond CHANNELS are
// processed with a count of zero and leave state alone. Configuration writes
// must happen only while no frame is in flight.
module load_aware_frame_skipper_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lafs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lafs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lafs_pkg::ChannelW-1:0]     channel_i,
  input  logic [lafs_pkg::LoadW-1:0]        system_load_i,
  input  logic                              is_active_i,
  input  logic [lafs_pkg::RateW-1:0]        channel_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              skip_o,
  output logic [lafs_pkg::CountW-1:0]       skip_count_o
);
  import lafs_pkg::*;

  // only channels reachable through the channel field get a counter
  localparam int unsigned Reach = 2 ** ChannelW;
  localparam int unsigned Depth = (CHANNELS < Reach) ? CHANNELS : Reach;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  cfg_t cfg_q;

  logic                s1_valid_q;
  logic [ChannelW-1:0] s1_channel_q;
  logic [LoadW-1:0]    s1_load_q;
  logic                s1_active_q;
  logic [RateW-1:0]    s1_rate_q;

  logic                out_valid_q;
  logic                out_skip_q;
  logic [CountW-1:0]   out_count_q;

  logic [CountW-1:0]   counts_q [Depth];

  logic                adv;
  logic                in_accept;
  logic                in_range;
  logic [IdxW-1:0]     idx;
  logic [CountW-1:0]   cur_count;
  logic                dec_skip;
  logic [CountW-1:0]   dec_count;
  logic                res_skip;
  logic [CountW-1:0]   res_count;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_threshold <= LoadW'(179);
      cfg_q.max_skips      <= CountW'(3);
      cfg_q.prio_active    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOAD_THRESHOLD: cfg_q.load_threshold <= cfg_wdata_i[LoadW-1:0];
        CFG_MAX_SKIPS:      cfg_q.max_skips      <= cfg_wdata_i[CountW-1:0];
        CFG_PRIO_ACTIVE:    cfg_q.prio_active    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_channel_q <= channel_i;
      s1_load_q    <= system_load_i;
      s1_active_q  <= is_active_i;
      s1_rate_q    <= channel_rate_i;
    end
  end

  // counter lookup and decision
  assign in_range  = {1'b0, s1_channel_q} < (ChannelW + 1)'(Depth);
  assign idx       = s1_channel_q[IdxW-1:0];
  assign cur_count = counts_q[idx];

  lafs_decide u_decide (
    .cfg_i    (cfg_q),
    .count_i  (cur_count),
    .load_i   (s1_load_q),
    .active_i (s1_active_q),
    .rate_i   (s1_rate_q),
    .skip_o   (dec_skip),
    .count_o  (dec_count)
  );

  assign res_skip  = in_range && dec_skip;
  assign res_count = in_range ? dec_count : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        counts_q[i] <= '0;
      end
    end else if (s1_valid_q && adv && in_range) begin
      counts_q[idx] <= dec_count;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_skip_q  <= res_skip;
      out_count_q <= res_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign skip_o       = out_skip_q;
  assign skip_count_o = out_count_q;

  a_process_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !skip_o |-> skip_count_o == '0)
    else $error("processed word with nonzero skip count");

  a_skip_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skip_o |-> skip_count_o != '0)
    else $error("skipped word with zero skip count");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skip_o |-> skip_count_o <= cfg_q.max_skips)
    else $error("skip count beyond configured maximum");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free pipeline");

  a_range_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !in_range |-> !res_skip && res_count == '0)
    else $error("out-of-range channel produced a skip");

endmodule

FILE: rtl/lafs_decide.sv
`timescale 1ns / 1ps

module lafs_decide (
  input  lafs_pkg::cfg_t                       cfg_i,
  input  logic [lafs_pkg::CountW-1:0]          count_i,
  input  logic [lafs_pkg::LoadW-1:0]           load_i,
  input  logic                                 active_i,
  input  logic [lafs_pkg::RateW-1:0]           rate_i,
  output logic                                 skip_o,
  output logic [lafs_pkg::CountW-1:0]          count_o
);
  import lafs_pkg::*;

  logic [CountW-1:0] half_max;

  assign half_max = cfg_i.max_skips >> 1;

  always_comb begin
    if (load_i < cfg_i.load_threshold) begin
      skip_o = 1'b0;
    end else if (count_i >= cfg_i.max_skips) begin
      skip_o = 1'b0;
    end else if (cfg_i.prio_active && active_i) begin
      skip_o = (load_i > LoadHigh) && (count_i < half_max);
    end else if (!active_i) begin
      skip_o = load_i > cfg_i.load_threshold;
    end else begin
      skip_o = rate_i > RateFast;
    end
  end

  always_comb begin
    if (!skip_o) begin
      count_o = '0;
    end else if (count_i == CountTop) begin
      count_o = count_i;
    end else begin
      count_o = count_i + CountW'(1);
    end
  end

endmodule
